// ===== hdl/oms_pkg.sv =====
// Shared types and constants for the odometry move sequencer.
// Holds opcode and register-index codes, mode/phase enums and wheel speeds.
// No dependencies.
package oms_pkg;

  localparam logic [2:0] OP_SENSOR = 3'd0;
  localparam logic [2:0] OP_FWD    = 3'd1;
  localparam logic [2:0] OP_BACK   = 3'd2;
  localparam logic [2:0] OP_AVOID  = 3'd3;
  localparam logic [2:0] OP_STOP   = 3'd4;
  localparam logic [2:0] OP_TURN   = 3'd5;

  localparam logic CFG_RIGHT_TURN = 1'b0;
  localparam logic CFG_LEFT_TURN  = 1'b1;

  localparam logic signed [9:0] RIGHT_TURN_RESET = -10'sd90;
  localparam logic signed [9:0] LEFT_TURN_RESET  = 10'sd90;

  localparam logic signed [8:0] SPEED_DRIVE = 9'sd250;
  localparam logic signed [8:0] SPEED_TURN  = 9'sd100;
  localparam logic signed [8:0] SPEED_STOP  = 9'sd0;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_AVOID = 3'd3,
    MODE_STOP  = 3'd4,
    MODE_TURN  = 3'd5
  } move_mode_t;

  typedef enum logic [2:0] {
    PH_NONE  = 3'd0,
    PH_BACK  = 3'd1,
    PH_TURN1 = 3'd2,
    PH_FWD   = 3'd3,
    PH_TURN2 = 3'd4
  } detour_phase_t;

  typedef struct packed {
    move_mode_t    move_mode;
    detour_phase_t detour_phase;
    logic          discard_next;
    logic          bump_seen;
    logic          left_first;
  } ctrl_t;

  typedef struct packed {
    logic signed [8:0] left;
    logic signed [8:0] right;
  } wheel_t;

endpackage

// ===== hdl/oms_step.sv =====
// Next-state and result logic for one item of the odometry move sequencer.
// Purely combinational; depends on oms_pkg.
module oms_step #(
  parameter int SUM_WIDTH = 24
) (
  input  oms_pkg::ctrl_t                ctrl,
  input  logic signed [SUM_WIDTH-1:0]   main_sum,
  input  logic signed [SUM_WIDTH-1:0]   main_target,
  input  logic signed [SUM_WIDTH-1:0]   sub_sum,
  input  oms_pkg::wheel_t               wheels,
  input  logic signed [9:0]             right_turn_angle,
  input  logic signed [9:0]             left_turn_angle,
  input  logic [2:0]                    opcode,
  input  logic signed [15:0]            target_amount,
  input  logic signed [9:0]             distance_delta,
  input  logic signed [8:0]             angle_delta,
  input  logic                          bump_left,
  input  logic                          bump_right,
  output oms_pkg::ctrl_t                ctrl_next,
  output logic signed [SUM_WIDTH-1:0]   main_sum_next,
  output logic signed [SUM_WIDTH-1:0]   main_target_next,
  output logic signed [SUM_WIDTH-1:0]   sub_sum_next,
  output oms_pkg::wheel_t               wheels_next,
  output logic                          done
);
  import oms_pkg::*;

  // Wide enough for target*10 and any sum plus a delta without overflow.
  localparam int EW = ((SUM_WIDTH > 20) ? SUM_WIDTH : 20) + 2;
  typedef logic signed [EW-1:0] ext_t;
  localparam ext_t SAT_HI = {{(EW-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
  localparam ext_t SAT_LO = ~SAT_HI;
  localparam ext_t DETOUR_BACK = ext_t'(100);
  localparam ext_t DETOUR_FWD  = ext_t'(200);

  function automatic logic signed [SUM_WIDTH-1:0] sat(input ext_t v);
    if (v > SAT_HI) return SAT_HI[SUM_WIDTH-1:0];
    else if (v < SAT_LO) return SAT_LO[SUM_WIDTH-1:0];
    else return v[SUM_WIDTH-1:0];
  endfunction

  function automatic logic turn_running(input ext_t sum, input ext_t goal);
    return (goal > 0) ? (sum <= goal) : (sum >= goal);
  endfunction

  function automatic wheel_t turn_wheels(input ext_t goal);
    wheel_t w;
    if (goal > 0) begin
      w.left  = SPEED_TURN;
      w.right = -SPEED_TURN;
    end else begin
      w.left  = -SPEED_TURN;
      w.right = SPEED_TURN;
    end
    return w;
  endfunction

  ext_t t_ext, dist_x, ang_x, first_ang, second_ang;
  logic signed [SUM_WIDTH-1:0] fwd_target, turn_target, reduced_target;
  logic signed [SUM_WIDTH-1:0] main_dist, main_ang, sub_step;
  logic detour_dist;

  assign t_ext          = ext_t'(target_amount);
  assign dist_x         = ext_t'(distance_delta);
  assign ang_x          = ext_t'(angle_delta);
  assign fwd_target     = sat((t_ext <<< 3) + (t_ext <<< 1));
  assign turn_target    = sat(t_ext);
  assign reduced_target = sat(ext_t'(main_target) - DETOUR_BACK);
  assign main_dist      = sat(ext_t'(main_sum) + dist_x);
  assign main_ang       = sat(ext_t'(main_sum) + ang_x);
  assign detour_dist    = (ctrl.detour_phase == PH_BACK) || (ctrl.detour_phase == PH_FWD);
  assign sub_step       = sat(ext_t'(sub_sum) + (detour_dist ? dist_x : ang_x));
  assign first_ang      = ext_t'(ctrl.left_first ? left_turn_angle : right_turn_angle);
  assign second_ang     = ext_t'(ctrl.left_first ? right_turn_angle : left_turn_angle);

  always_comb begin
    logic finish;
    logic running;
    finish           = 1'b0;
    running          = 1'b1;
    ctrl_next        = ctrl;
    main_sum_next    = main_sum;
    main_target_next = main_target;
    sub_sum_next     = sub_sum;
    wheels_next      = wheels;

    unique case (opcode) inside
      OP_FWD, OP_BACK, OP_AVOID, OP_STOP, OP_TURN: begin
        ctrl_next.detour_phase = PH_NONE;
        ctrl_next.bump_seen    = 1'b0;
        ctrl_next.discard_next = 1'b1;
        main_sum_next          = '0;
        sub_sum_next           = '0;
        unique case (opcode)
          OP_FWD:   ctrl_next.move_mode = MODE_FWD;
          OP_BACK:  ctrl_next.move_mode = MODE_BACK;
          OP_AVOID: ctrl_next.move_mode = MODE_AVOID;
          OP_STOP:  ctrl_next.move_mode = MODE_STOP;
          default:  ctrl_next.move_mode = MODE_TURN;
        endcase
        if (opcode == OP_TURN) begin
          // Zero always lies inside a turn's window: it needs one counted item.
          main_target_next = turn_target;
          wheels_next      = turn_wheels(ext_t'(turn_target));
        end else begin
          main_target_next = fwd_target;
          if (opcode == OP_BACK) begin
            wheels_next.left  = -SPEED_DRIVE;
            wheels_next.right = -SPEED_DRIVE;
          end else begin
            wheels_next.left  = SPEED_DRIVE;
            wheels_next.right = SPEED_DRIVE;
          end
          finish = !(fwd_target > 0);
        end
      end
      OP_SENSOR: begin
        if (ctrl.move_mode != MODE_IDLE) begin
          if (ctrl.discard_next) begin
            ctrl_next.discard_next = 1'b0;
          end else if (ctrl.detour_phase != PH_NONE) begin
            sub_sum_next = sub_step;
            case (ctrl.detour_phase)
              PH_BACK:  running = ext_t'(sub_step) > -DETOUR_BACK;
              PH_TURN1: running = turn_running(ext_t'(sub_step), first_ang);
              PH_FWD:   running = ext_t'(sub_step) < DETOUR_FWD;
              default:  running = turn_running(ext_t'(sub_step), second_ang);
            endcase
            if (!running) begin
              sub_sum_next           = '0;
              ctrl_next.discard_next = 1'b1;
              case (ctrl.detour_phase)
                PH_BACK: begin
                  ctrl_next.detour_phase = PH_TURN1;
                  wheels_next            = turn_wheels(first_ang);
                end
                PH_TURN1: begin
                  ctrl_next.detour_phase = PH_FWD;
                  wheels_next.left       = SPEED_DRIVE;
                  wheels_next.right      = SPEED_DRIVE;
                end
                PH_FWD: begin
                  ctrl_next.detour_phase = PH_TURN2;
                  wheels_next            = turn_wheels(second_ang);
                end
                default: begin
                  ctrl_next.detour_phase = PH_NONE;
                  main_target_next       = reduced_target;
                  wheels_next.left       = SPEED_DRIVE;
                  wheels_next.right      = SPEED_DRIVE;
                  finish                 = !(main_sum < reduced_target);
                end
              endcase
            end
          end else begin
            case (ctrl.move_mode)
              MODE_FWD: begin
                main_sum_next = main_dist;
                finish        = !(main_dist < main_target);
              end
              MODE_BACK: begin
                main_sum_next = main_dist;
                finish        = !((ext_t'(main_dist) + ext_t'(main_target)) > 0);
              end
              MODE_AVOID: begin
                main_sum_next = main_dist;
                if (bump_left || bump_right) begin
                  ctrl_next.bump_seen    = 1'b1;
                  ctrl_next.left_first   = !bump_left;
                  ctrl_next.detour_phase = PH_BACK;
                  ctrl_next.discard_next = 1'b1;
                  sub_sum_next           = '0;
                  wheels_next.left       = -SPEED_DRIVE;
                  wheels_next.right      = -SPEED_DRIVE;
                end else begin
                  finish = !(main_dist < main_target);
                end
              end
              MODE_STOP: begin
                main_sum_next = main_dist;
                if (bump_left || bump_right) begin
                  ctrl_next.bump_seen = 1'b1;
                  finish              = 1'b1;
                end else begin
                  finish = !(main_dist < main_target);
                end
              end
              MODE_TURN: begin
                main_sum_next = main_ang;
                finish = !turn_running(ext_t'(main_ang), ext_t'(main_target));
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase

    if (finish) begin
      ctrl_next.move_mode    = MODE_IDLE;
      ctrl_next.detour_phase = PH_NONE;
      ctrl_next.discard_next = 1'b0;
      wheels_next.left       = SPEED_STOP;
      wheels_next.right      = SPEED_STOP;
    end
    done = finish;
  end

endmodule

// ===== hdl/odometry_move_sequencer_top.sv =====
// Top level of the odometry move sequencer: handshakes, state and registers.
// Depends on oms_pkg and oms_step.
//
// Drives a two-wheel robot from odometry. Command items (opcodes 1..5) start
// forward, backward, forward-avoiding, forward-stop-on-bump or turn moves;
// sensor items (opcode 0) add travelled mm or turned degrees to the running
// sum until the target is met, then the wheels stop and done_res pulses for
// that one result. In avoiding mode a bump runs a detour (back 10 cm, turn,
// forward 20 cm, turn back) and shortens the main target by 10 cm. The first
// sensor item after every start or phase change is dropped. Every item gives
// exactly one result, carrying the wheel command in force after it. One item
// per cycle is sustained while out_ready drains the result register; the
// transfer loads the input register, and the step logic then runs into the
// result register once that is empty or being drained. The result register
// parts the two sides, so a new item is taken into an empty input register
// while the previous result still waits. Write the turn-angle registers
// only while no item is in flight; cfg_ready is always high.
module odometry_move_sequencer_top #(
  parameter int SUM_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [9:0]        cfg_data,
  // item channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        opcode,
  input  logic signed [15:0] target_amount,
  input  logic signed [9:0] distance_delta,
  input  logic signed [8:0] angle_delta,
  input  logic              bump_left,
  input  logic              bump_right,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [8:0] left_speed,
  output logic signed [8:0] right_speed,
  output logic              busy_res,
  output logic              done_res,
  output logic              bumped
);
  import oms_pkg::*;

  // Turn-angle registers
  logic signed [9:0] right_turn_angle;
  logic signed [9:0] left_turn_angle;

  // Input register
  logic              s1_valid;
  logic [2:0]        s1_opcode;
  logic signed [15:0] s1_target;
  logic signed [9:0] s1_dist;
  logic signed [8:0] s1_ang;
  logic              s1_bump_left;
  logic              s1_bump_right;

  // Sequencer state
  ctrl_t                      ctrl, ctrl_next;
  logic signed [SUM_WIDTH-1:0] main_sum, main_sum_next;
  logic signed [SUM_WIDTH-1:0] main_target, main_target_next;
  logic signed [SUM_WIDTH-1:0] sub_sum, sub_sum_next;
  wheel_t                     wheels, wheels_next;
  logic                       step_done;

  logic advance;
  logic step;

  // The result register moves when empty or being drained; the input
  // register refills whenever its item moves on.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign step      = s1_valid && advance;
  assign cfg_ready = 1'b1;

  oms_step #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_step (
    .ctrl             (ctrl),
    .main_sum         (main_sum),
    .main_target      (main_target),
    .sub_sum          (sub_sum),
    .wheels           (wheels),
    .right_turn_angle (right_turn_angle),
    .left_turn_angle  (left_turn_angle),
    .opcode           (s1_opcode),
    .target_amount    (s1_target),
    .distance_delta   (s1_dist),
    .angle_delta      (s1_ang),
    .bump_left        (s1_bump_left),
    .bump_right       (s1_bump_right),
    .ctrl_next        (ctrl_next),
    .main_sum_next    (main_sum_next),
    .main_target_next (main_target_next),
    .sub_sum_next     (sub_sum_next),
    .wheels_next      (wheels_next),
    .done             (step_done)
  );

  // Configuration registers: take a write on every transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      right_turn_angle <= RIGHT_TURN_RESET;
      left_turn_angle  <= LEFT_TURN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RIGHT_TURN: right_turn_angle <= cfg_data;
        CFG_LEFT_TURN:  left_turn_angle  <= cfg_data;
      endcase
    end
  end

  // Input register: hold the item until the step logic consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_opcode     <= opcode;
      s1_target     <= target_amount;
      s1_dist       <= distance_delta;
      s1_ang        <= angle_delta;
      s1_bump_left  <= bump_left;
      s1_bump_right <= bump_right;
    end
  end

  // State and result register: advance both on each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.move_mode    <= MODE_IDLE;
      ctrl.detour_phase <= PH_NONE;
      ctrl.discard_next <= 1'b0;
      ctrl.bump_seen    <= 1'b0;
      ctrl.left_first   <= 1'b0;
      main_sum          <= '0;
      main_target       <= '0;
      sub_sum           <= '0;
      wheels.left       <= SPEED_STOP;
      wheels.right      <= SPEED_STOP;
      out_valid         <= 1'b0;
    end else begin
      if (step) begin
        ctrl        <= ctrl_next;
        main_sum    <= main_sum_next;
        main_target <= main_target_next;
        sub_sum     <= sub_sum_next;
        wheels      <= wheels_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (step) begin
      left_speed  <= wheels_next.left;
      right_speed <= wheels_next.right;
      busy_res    <= (ctrl_next.move_mode != MODE_IDLE);
      done_res    <= step_done;
      bumped      <= ctrl_next.bump_seen;
    end
  end

endmodule
